// ===== src/pdi_pkg.sv =====
// Package for the path distance interpolator: codes, field layout of the stream
// words, controller states and the command/status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pdi_pkg;

  localparam int RECORDS_DEF = 32;
  localparam int SUB_SEGMENTS_DEF = 10;
  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic [4:0] MAX_EVENTS = 5'd31;

  // opcodes carried in the input tuser
  localparam logic [2:0] OP_LOAD_LEN = 3'd0;
  localparam logic [2:0] OP_LOAD_SUB = 3'd1;
  localparam logic [2:0] OP_LOAD_PT = 3'd2;
  localparam logic [2:0] OP_LOAD_EVT = 3'd3;
  localparam logic [2:0] OP_QUERY = 3'd4;
  localparam logic [2:0] OP_RESTART = 3'd5;

  // result kinds carried in the output tuser
  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_ANSWER = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_ACTIVE = 2'd0;
  localparam logic [1:0] REG_COUNT = 2'd1;
  localparam logic [1:0] REG_ZLIMIT = 2'd2;
  localparam logic [1:0] REG_DEFFRAC = 2'd3;

  // input tdata layout
  localparam int IN_DW = 208;
  localparam int IN_REC_LO = 0;
  localparam int IN_SLOT_LO = 5;
  localparam int IN_LEN_LO = 9;
  localparam int IN_X_LO = 41;
  localparam int IN_Y_LO = 73;
  localparam int IN_Z_LO = 105;
  localparam int IN_EVT_LO = 137;
  localparam int IN_TRAV_LO = 169;
  localparam int IN_NOTIFY = 201;
  localparam int IN_WANTD = 202;

  // output tdata layout
  localparam int OUT_DW = 168;

  typedef struct packed {
    logic        active;
    logic [5:0]  record_count;
    logic [31:0] zero_length_limit;
    logic [16:0] default_fraction;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FAIL,
    ST_REC_RD,
    ST_REC_CHK,
    ST_EVT,
    ST_SUB_RD,
    ST_SUB_CHK,
    ST_DIV,
    ST_FROM_RD,
    ST_TO_RD,
    ST_D0_RD,
    ST_D9_RD,
    ST_DLT,
    ST_MUL,
    ST_ADD,
    ST_ANS
  } state_t;

  typedef struct packed {
    logic accept;
    logic q_start;
    logic rec_rd;
    logic rec_pass;
    logic rem_init;
    logic sub_rd;
    logic sub_step;
    logic frac_set;
    logic div_step;
    logic from_rd;
    logic to_rd;
    logic d0_rd;
    logic d9_rd;
    logic dlt;
    logic mul;
    logic add;
    logic emit_evt;
    logic emit_fail;
    logic emit_ans;
  } cmd_t;

  typedef struct packed {
    logic entry_fail;
    logic rec_stay;
    logic evt_ok;
    logic pass_fail;
    logic sub_more;
    logic div_needed;
    logic div_last;
    logic axis_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/pdi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pdi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== src/pdi_dp.sv =====
// Datapath: path table memories, walk registers, fraction divider, interpolator
// and output register. Depends on pdi_pkg and pdi_ram.
`timescale 1ns / 1ps
`default_nettype none
module pdi_dp #(
  parameter int RECORDS = pdi_pkg::RECORDS_DEF,
  parameter int SUB_SEGMENTS = pdi_pkg::SUB_SEGMENTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pdi_pkg::cmd_t                cmd,
  output pdi_pkg::sts_t                sts,
  input  pdi_pkg::cfg_t                cfg,
  input  logic [2:0]                   in_op,
  input  logic [pdi_pkg::IN_DW-1:0]    in_data,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic                         out_kind,
  output logic [pdi_pkg::OUT_DW-1:0]   out_data,
  output logic                         out_last
);
  import pdi_pkg::*;

  localparam int POINTS = SUB_SEGMENTS + 1;
  localparam int RW = $clog2(RECORDS);
  localparam int SAW = $clog2(RECORDS * SUB_SEGMENTS);
  localparam int PAW = $clog2(RECORDS * POINTS);
  localparam int CW = $clog2(RECORDS + 1);
  localparam int SW = (SUB_SEGMENTS > 1) ? $clog2(SUB_SEGMENTS) : 1;
  localparam int CMPW = ((CW > 6) ? CW : 6) + 1;

  // input fields
  logic [4:0]  in_rec;
  logic [3:0]  in_slot;
  logic [31:0] in_len, in_x, in_y, in_z, in_evt, in_trav;
  assign in_rec  = in_data[IN_REC_LO +: 5];
  assign in_slot = in_data[IN_SLOT_LO +: 4];
  assign in_len  = in_data[IN_LEN_LO +: 32];
  assign in_x    = in_data[IN_X_LO +: 32];
  assign in_y    = in_data[IN_Y_LO +: 32];
  assign in_z    = in_data[IN_Z_LO +: 32];
  assign in_evt  = in_data[IN_EVT_LO +: 32];
  assign in_trav = in_data[IN_TRAV_LO +: 32];

  // walk state
  logic [CW-1:0]     cur_r;
  logic [31:0]       dbr_r, dir_r;
  logic [SW-1:0]     sub_r;
  logic [31:0]       trav_r;
  logic              notify_r, wantd_r;
  logic [4:0]        nres_r;
  logic signed [34:0] rem_r;
  logic [31:0]       len_r;
  logic [16:0]       t_r;
  logic [31:0]       div_r;
  logic [15:0]       divq_r;
  logic [3:0]        divcnt_r;
  logic [95:0]       from_r, to_r;
  logic [32:0]       a_r;
  logic [31:0]       delta_r;
  logic signed [50:0] prod_r;
  logic [1:0]        axis_r;
  logic [31:0]       pos_x_r, pos_y_r, pos_z_r;

  // memories
  logic            rec_ok;
  logic            len_we, sub_we, pt_we, evt_we;
  logic [31:0]     sub_wa32, pt_wa32;
  logic [31:0]     rl_q, evt_q, sub_q;
  logic [95:0]     pt_q;
  logic [CW-1:0]   cur_p2;
  logic [31:0]     sub_base, pt_base, pt_next_base;
  logic [SAW-1:0]  sub_ra;
  logic [PAW-1:0]  pt_ra;

  assign rec_ok = 32'(in_rec) < RECORDS;
  assign len_we = cmd.accept && in_op == OP_LOAD_LEN && rec_ok;
  assign evt_we = cmd.accept && in_op == OP_LOAD_EVT && rec_ok;
  assign sub_we = cmd.accept && in_op == OP_LOAD_SUB && rec_ok
                  && 32'(in_slot) < SUB_SEGMENTS;
  assign pt_we  = cmd.accept && in_op == OP_LOAD_PT && rec_ok && 32'(in_slot) < POINTS;
  assign sub_wa32 = 32'(in_rec) * 32'(SUB_SEGMENTS) + 32'(in_slot);
  assign pt_wa32  = 32'(in_rec) * 32'(POINTS) + 32'(in_slot);

  assign cur_p2 = cur_r + CW'(2);
  assign sub_base = 32'(cur_r) * 32'(SUB_SEGMENTS);
  assign pt_base = 32'(cur_r) * 32'(POINTS);
  assign pt_next_base = pt_base + 32'(POINTS);

  always_comb begin
    if (cmd.d0_rd) begin
      sub_ra = SAW'(sub_base);
    end else if (cmd.d9_rd) begin
      sub_ra = SAW'(sub_base + 32'(SUB_SEGMENTS - 1));
    end else begin
      sub_ra = SAW'(sub_base + 32'(sub_r));
    end
    if (cmd.to_rd) begin
      pt_ra = PAW'(pt_base + 32'(sub_r));
    end else if (sub_r != '0) begin
      pt_ra = PAW'(pt_base + 32'(sub_r) - 32'd1);
    end else begin
      pt_ra = PAW'(pt_next_base + 32'(SUB_SEGMENTS));
    end
  end

  pdi_ram #(.WIDTH(32), .DEPTH(RECORDS)) u_len_ram (
    .clk(clk), .we(len_we), .waddr(RW'(in_rec)), .wdata(in_len),
    .re(cmd.rec_rd), .raddr(cur_r[RW-1:0]), .rdata(rl_q)
  );
  pdi_ram #(.WIDTH(32), .DEPTH(RECORDS)) u_evt_ram (
    .clk(clk), .we(evt_we), .waddr(RW'(in_rec)), .wdata(in_evt),
    .re(cmd.rec_rd), .raddr(cur_p2[RW-1:0]), .rdata(evt_q)
  );
  pdi_ram #(.WIDTH(32), .DEPTH(RECORDS * SUB_SEGMENTS)) u_sub_ram (
    .clk(clk), .we(sub_we), .waddr(SAW'(sub_wa32)), .wdata(in_len),
    .re(cmd.sub_rd || cmd.d0_rd || cmd.d9_rd), .raddr(sub_ra), .rdata(sub_q)
  );
  pdi_ram #(.WIDTH(96), .DEPTH(RECORDS * POINTS)) u_pt_ram (
    .clk(clk), .we(pt_we), .waddr(PAW'(pt_wa32)), .wdata({in_z, in_y, in_x}),
    .re(cmd.from_rd || cmd.to_rd), .raddr(pt_ra), .rdata(pt_q)
  );

  // status
  logic [CMPW-1:0]    count, cur_ext;
  logic signed [33:0] rec_diff;
  logic signed [34:0] len_ext;
  assign count = (32'(cfg.record_count) > RECORDS) ? CMPW'(RECORDS)
                                                    : CMPW'(cfg.record_count);
  assign cur_ext = CMPW'(cur_r);
  assign rec_diff = $signed({2'b00, trav_r}) - $signed({2'b00, dbr_r});
  assign len_ext = $signed({3'b000, sub_q});

  logic [32:0] div_sh;
  logic        div_ge;
  logic [15:0] divq_nxt;
  assign div_sh = {div_r, 1'b0};
  assign div_ge = div_sh >= {1'b0, len_r};
  assign divq_nxt = {divq_r[14:0], div_ge};

  assign sts.entry_fail = !cfg.active || (cur_ext + CMPW'(3) > count);
  assign sts.rec_stay = rec_diff < $signed({2'b00, rl_q});
  assign sts.evt_ok = notify_r && nres_r != MAX_EVENTS;
  assign sts.pass_fail = cur_ext + CMPW'(4) > count;
  assign sts.sub_more = rem_r >= len_ext && 32'(sub_r) != SUB_SEGMENTS - 1;
  assign sts.div_needed = sub_q > cfg.zero_length_limit && rem_r > 35'sd0 && rem_r < len_ext;
  assign sts.div_last = divcnt_r == 4'd15;
  assign sts.axis_last = axis_r == 2'd2;
  assign sts.out_free = !out_valid || out_ready;

  // interpolation operands for the current axis
  logic [31:0]        from_ax, to_ax;
  logic signed [32:0] d_ax;
  logic signed [50:0] prod_sh;
  logic [31:0]        pos_ax;
  always_comb begin
    case (axis_r)
      2'd0:    begin from_ax = from_r[31:0];  to_ax = to_r[31:0];  end
      2'd1:    begin from_ax = from_r[63:32]; to_ax = to_r[63:32]; end
      default: begin from_ax = from_r[95:64]; to_ax = to_r[95:64]; end
    endcase
  end
  assign d_ax = $signed({to_ax[31], to_ax}) - $signed({from_ax[31], from_ax});
  assign prod_sh = prod_r >>> 16;
  assign pos_ax = from_ax + prod_sh[31:0];

  logic [32:0] s_diff, s_abs, ab_diff, ab_abs;
  assign s_diff = {1'b0, sub_q} - {1'b0, trav_r};
  assign s_abs = s_diff[32] ? (33'd0 - s_diff) : s_diff;
  assign ab_diff = a_r - s_abs;
  assign ab_abs = ab_diff[32] ? (33'd0 - ab_diff) : ab_diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      dbr_r <= '0;
      dir_r <= '0;
      sub_r <= '0;
    end else begin
      if (cmd.accept && in_op == OP_RESTART) begin
        cur_r <= '0;
        dbr_r <= '0;
        dir_r <= '0;
        sub_r <= '0;
      end
      if (cmd.rec_pass) begin
        dbr_r <= dbr_r + rl_q;
        cur_r <= cur_r + CW'(1);
        dir_r <= '0;
        sub_r <= '0;
      end
      if (cmd.sub_step) begin
        dir_r <= dir_r + sub_q;
        sub_r <= sub_r + SW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      trav_r <= in_trav;
      notify_r <= in_data[IN_NOTIFY];
      wantd_r <= in_data[IN_WANTD];
      nres_r <= '0;
    end
    if (cmd.emit_evt) begin
      nres_r <= nres_r + 5'd1;
    end
    if (cmd.rem_init) begin
      rem_r <= $signed({3'b000, trav_r}) - $signed({3'b000, dbr_r})
               - $signed({3'b000, dir_r});
    end
    if (cmd.sub_step) begin
      rem_r <= rem_r - len_ext;
    end
    if (cmd.frac_set) begin
      len_r <= sub_q;
      div_r <= rem_r[31:0];
      divq_r <= '0;
      divcnt_r <= '0;
      if (sub_q > cfg.zero_length_limit) begin
        if (rem_r <= 35'sd0) begin
          t_r <= '0;
        end else if (rem_r >= len_ext) begin
          t_r <= ONE_Q16;
        end
      end else begin
        t_r <= (cfg.default_fraction > ONE_Q16) ? ONE_Q16 : cfg.default_fraction;
      end
    end
    if (cmd.div_step) begin
      div_r <= div_ge ? 32'(div_sh - {1'b0, len_r}) : div_sh[31:0];
      divq_r <= divq_nxt;
      divcnt_r <= divcnt_r + 4'd1;
      if (divcnt_r == 4'd15) begin
        t_r <= {1'b0, divq_nxt};
      end
    end
    if (cmd.to_rd) begin
      from_r <= pt_q;
    end
    if (cmd.d0_rd) begin
      to_r <= pt_q;
    end
    if (cmd.d9_rd) begin
      a_r <= s_abs;
    end
    if (cmd.dlt) begin
      delta_r <= wantd_r ? ab_abs[31:0] : '0;
      axis_r <= '0;
    end
    if (cmd.mul) begin
      prod_r <= d_ax * $signed({1'b0, t_r});
    end
    if (cmd.add) begin
      axis_r <= axis_r + 2'd1;
      case (axis_r)
        2'd0:    pos_x_r <= pos_ax;
        2'd1:    pos_y_r <= pos_ax;
        default: pos_z_r <= pos_ax;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_evt || cmd.emit_fail || cmd.emit_ans) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_evt) begin
      out_kind <= KIND_EVENT;
      out_last <= 1'b0;
      out_data <= {{(OUT_DW - 32){1'b0}}, evt_q};
    end else if (cmd.emit_fail) begin
      out_kind <= KIND_ANSWER;
      out_last <= 1'b1;
      out_data <= '0;
    end else if (cmd.emit_ans) begin
      out_kind <= KIND_ANSWER;
      out_last <= 1'b1;
      out_data <= {7'b0, delta_r, pos_z_r, pos_y_r, pos_x_r, 1'b1, 32'b0};
    end
  end
endmodule
`default_nettype wire

// ===== src/pdi_ctrl.sv =====
// Controller: sequences loads, the record walk, the sub-segment walk, the
// divider, the point reads and the interpolation. Depends on pdi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pdi_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [2:0]    in_op,
  output logic          in_ready,
  input  pdi_pkg::sts_t sts,
  output pdi_pkg::cmd_t cmd
);
  import pdi_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_op == OP_QUERY) begin
            cmd.q_start = 1'b1;
            state_nxt = sts.entry_fail ? ST_FAIL : ST_REC_RD;
          end
        end
      end
      ST_FAIL: begin
        if (sts.out_free) begin
          cmd.emit_fail = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_REC_RD: begin
        cmd.rec_rd = 1'b1;
        state_nxt = ST_REC_CHK;
      end
      ST_REC_CHK: begin
        if (sts.rec_stay) begin
          cmd.rem_init = 1'b1;
          state_nxt = ST_SUB_RD;
        end else if (sts.evt_ok) begin
          state_nxt = ST_EVT;
        end else begin
          cmd.rec_pass = 1'b1;
          state_nxt = sts.pass_fail ? ST_FAIL : ST_REC_RD;
        end
      end
      ST_EVT: begin
        // hold until the output register can take the word
        if (sts.out_free) begin
          cmd.emit_evt = 1'b1;
          cmd.rec_pass = 1'b1;
          state_nxt = sts.pass_fail ? ST_FAIL : ST_REC_RD;
        end
      end
      ST_SUB_RD: begin
        cmd.sub_rd = 1'b1;
        state_nxt = ST_SUB_CHK;
      end
      ST_SUB_CHK: begin
        if (sts.sub_more) begin
          cmd.sub_step = 1'b1;
          state_nxt = ST_SUB_RD;
        end else begin
          cmd.frac_set = 1'b1;
          state_nxt = sts.div_needed ? ST_DIV : ST_FROM_RD;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_FROM_RD;
        end
      end
      ST_FROM_RD: begin
        cmd.from_rd = 1'b1;
        state_nxt = ST_TO_RD;
      end
      ST_TO_RD: begin
        cmd.to_rd = 1'b1;
        state_nxt = ST_D0_RD;
      end
      ST_D0_RD: begin
        cmd.d0_rd = 1'b1;
        state_nxt = ST_D9_RD;
      end
      ST_D9_RD: begin
        cmd.d9_rd = 1'b1;
        state_nxt = ST_DLT;
      end
      ST_DLT: begin
        cmd.dlt = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        state_nxt = sts.axis_last ? ST_ANS : ST_MUL;
      end
      ST_ANS: begin
        if (sts.out_free) begin
          cmd.emit_ans = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

// ===== src/path_distance_interpolator.sv =====
// Top level of the path distance interpolator: configuration registers,
// controller and datapath. Depends on pdi_pkg, pdi_ctrl, pdi_dp (and pdi_ram).
//
//   channel | dir | handshake               | payload
//   in_     | in  | in_tvalid / in_tready    | in_tuser opcode, in_tdata fields
//   out_    | out | out_tvalid / out_tready  | out_tuser kind, out_tdata, out_tlast
//   cfg_    | in  | psel, penable, pready    | paddr, pwdata, prdata
//
// Loads and restart are taken in the idle state. A query enters, checks each
// record and emits any event word, checks each sub-segment, runs the fraction
// division when the remainder lies strictly inside a sub-segment above the
// zero limit, reads the points and end lengths, runs the three-axis
// interpolation and presents the answer. A query failing on entry goes
// straight to the failed answer.
// Reset is synchronous and active low; table memories are not cleared.
// A full output register stalls the walk at the next word; in_tready is low
// while a query runs.
`timescale 1ns / 1ps
`default_nettype none
module path_distance_interpolator #(
  parameter int RECORDS = pdi_pkg::RECORDS_DEF,
  parameter int SUB_SEGMENTS = pdi_pkg::SUB_SEGMENTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // record_index, slot_index, length_value, point_x, point_y, point_z,
  // event_code, travelled, notify, want_delta
  input  logic [pdi_pkg::IN_DW-1:0]  in_tdata,
  input  logic [2:0]                 in_tuser,   // opcode
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // event_out, ok, pos_x, pos_y, pos_z, delta
  output logic [pdi_pkg::OUT_DW-1:0] out_tdata,
  output logic                       out_tuser,  // kind
  output logic                       out_tlast,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [3:0]                 cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import pdi_pkg::*;

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_ACTIVE:  cfg_r.active <= cfg_pwdata[0];
        REG_COUNT:   cfg_r.record_count <= cfg_pwdata[5:0];
        REG_ZLIMIT:  cfg_r.zero_length_limit <= cfg_pwdata;
        REG_DEFFRAC: cfg_r.default_fraction <= cfg_pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_ACTIVE:  cfg_prdata = {31'b0, cfg_r.active};
      REG_COUNT:   cfg_prdata = {26'b0, cfg_r.record_count};
      REG_ZLIMIT:  cfg_prdata = cfg_r.zero_length_limit;
      REG_DEFFRAC: cfg_prdata = {15'b0, cfg_r.default_fraction};
      default:     cfg_prdata = '0;
    endcase
  end

  pdi_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_op(in_tuser),
    .in_ready(in_tready), .sts(sts), .cmd(cmd)
  );

  pdi_dp #(.RECORDS(RECORDS), .SUB_SEGMENTS(SUB_SEGMENTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .cfg(cfg_r),
    .in_op(in_tuser), .in_data(in_tdata), .out_ready(out_tready),
    .out_valid(out_tvalid), .out_kind(out_tuser), .out_data(out_tdata),
    .out_last(out_tlast)
  );

  a_evt_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_EVENT |-> !out_tlast && !out_tdata[32])
    else $error("event word marked last or ok");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_QUERY |=> !in_tready)
    else $error("input taken during a query");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ANSWER && !out_tdata[32] |-> out_tdata[160:33] == '0)
    else $error("failed answer carries a position");
endmodule
`default_nettype wire
